/* sv/stable_priority_queue_unit_defines.svh */
// Assertion macros for the stable priority queue checker.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stable priority queue check failed");

// Next-cycle implication, checked while out of reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stable priority queue check failed");

`endif

/* sv/spq_pkg.sv */
// Shared types, sizes, codes and ring pointer helpers for the stable priority queue.
// Depends on nothing.
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 8;
	localparam int TAG_BITS  = 16;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW        = $clog2(DEPTH + 1);
	localparam int SW        = AW + 1;
	localparam int EW        = PRIO_BITS + TAG_BITS;

	typedef logic [AW-1:0]        ptr_t;
	typedef logic [CW-1:0]        cnt_t;
	typedef logic [PRIO_BITS-1:0] prio_t;
	typedef logic [TAG_BITS-1:0]  tag_t;

	typedef struct packed {
		prio_t prio;
		tag_t  tag;
	} entry_t;

	// Request kinds
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PUSH_CMP,
		S_PUSH_FIRST,
		S_POP_OUT
	} state_t;

	// One finished request, handed from sequencer to output register
	typedef struct packed {
		logic    valid;
		logic    pop_valid;
		prio_t   prio;
		tag_t    tag;
		status_t status;
		cnt_t    occupancy;
	} res_t;

	function automatic ptr_t ptr_inc(ptr_t p);
		return (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	function automatic ptr_t ptr_dec(ptr_t p);
		return (p == '0) ? ptr_t'(DEPTH - 1) : ptr_t'(p - 1'b1);
	endfunction

	// base + off on the ring, off below DEPTH
	function automatic ptr_t ptr_add(ptr_t base, cnt_t off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
		return ptr_t'(sum);
	endfunction

endpackage

/* sv/spq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/spq_ctrl.sv */
// Sequencer for the stable priority queue: ring pointers, entry count and the
// shared priority comparator that walks the store one entry per cycle.
// Depends on spq_pkg; drives the ports of one spq_ram.
module spq_ctrl
	import spq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   kind,
	input  prio_t  priority_req,
	input  tag_t   payload_tag,
	output logic   busy,
	output logic   ram_wr_en,
	output ptr_t   ram_wr_addr,
	output entry_t ram_wr_data,
	output logic   ram_rd_en,
	output ptr_t   ram_rd_addr,
	input  entry_t ram_rd_data,
	output res_t   res
);

	state_t state_q, state_d;
	ptr_t   head_q, head_d;
	cnt_t   count_q, count_d;
	ptr_t   ptr_q, ptr_d;
	entry_t new_q, new_d;
	ptr_t   wr_next;

	// Hold state, ring head and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Scan pointer and pending entry
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		new_q <= new_d;
	end

	assign wr_next = ptr_inc(ptr_q);
	assign busy    = (state_q != S_IDLE);

	// Next state, memory accesses and result
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		ptr_d       = ptr_q;
		new_d       = new_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = head_q;
		ram_wr_data = new_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = head_q;
		res         = '0;
		res.status  = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind == KIND_POP) begin
						if (count_q == '0) begin
							res.valid     = 1'b1;
							res.status    = ST_EMPTY;
							res.occupancy = count_q;
						end else begin
							ram_rd_en = 1'b1;
							state_d   = S_POP_OUT;
						end
					end else if (count_q == cnt_t'(DEPTH)) begin
						res.valid     = 1'b1;
						res.status    = ST_FULL;
						res.occupancy = count_q;
					end else if (count_q == '0) begin
						// first entry goes straight in at the head
						ram_wr_en     = 1'b1;
						ram_wr_data   = '{prio: priority_req, tag: payload_tag};
						count_d       = cnt_t'(1);
						res.valid     = 1'b1;
						res.occupancy = cnt_t'(1);
					end else begin
						// start the scan at the tail
						ram_rd_en   = 1'b1;
						ram_rd_addr = ptr_add(head_q, cnt_t'(count_q - 1'b1));
						ptr_d       = ram_rd_addr;
						new_d       = '{prio: priority_req, tag: payload_tag};
						state_d     = S_PUSH_CMP;
					end
				end
			end
			S_PUSH_CMP: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = wr_next;
				if (ram_rd_data.prio >= new_q.prio) begin
					// insert behind the last entry of equal or higher priority
					ram_wr_data   = new_q;
					count_d       = cnt_t'(count_q + 1'b1);
					res.valid     = 1'b1;
					res.occupancy = count_d;
					state_d       = S_IDLE;
				end else begin
					// advance the entry one place back, read the one before it
					ram_wr_data = ram_rd_data;
					if (ptr_q == head_q) begin
						state_d = S_PUSH_FIRST;
					end else begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = ptr_dec(ptr_q);
						ptr_d       = ram_rd_addr;
					end
				end
			end
			S_PUSH_FIRST: begin
				ram_wr_en     = 1'b1;
				ram_wr_addr   = head_q;
				ram_wr_data   = new_q;
				count_d       = cnt_t'(count_q + 1'b1);
				res.valid     = 1'b1;
				res.occupancy = count_d;
				state_d       = S_IDLE;
			end
			S_POP_OUT: begin
				head_d        = ptr_inc(head_q);
				count_d       = cnt_t'(count_q - 1'b1);
				res.valid     = 1'b1;
				res.pop_valid = 1'b1;
				res.prio      = ram_rd_data.prio;
				res.tag       = ram_rd_data.tag;
				res.occupancy = count_d;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* sv/stable_priority_queue_unit.sv */
// Top level of the stable priority queue: sequencer, entry RAM, result register.
// Depends on spq_pkg, spq_ctrl and spq_ram.
//
//  channel   handshake               fields
//  request   start, accepted !busy   kind, priority_req, payload_tag
//  result    result_valid strobe     pop_valid, out_priority, out_payload_tag,
//                                    status, occupancy
//
// Dropped push and empty pop: result in the cycle after the request, busy stays low.
// Pop: one RAM read of the head entry.
// Push: straight in at the head when the queue is empty; otherwise
// the shared comparator walks the store from the tail, one RAM read and one write a cycle.
// Reset clears the entry count and ring head; the RAM contents are not cleared.
// The result is shown for exactly one cycle; there is no back pressure.
module stable_priority_queue_unit
	import spq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 kind,
	input  logic [PRIO_BITS-1:0] priority_req,
	input  logic [TAG_BITS-1:0]  payload_tag,
	output logic                 result_valid,
	output logic                 pop_valid,
	output logic [PRIO_BITS-1:0] out_priority,
	output logic [TAG_BITS-1:0]  out_payload_tag,
	output logic [1:0]           status,
	output logic [CW-1:0]        occupancy
);

	logic   ram_wr_en;
	ptr_t   ram_wr_addr;
	entry_t ram_wr_data;
	logic   ram_rd_en;
	ptr_t   ram_rd_addr;
	logic [EW-1:0] ram_rd_bits;
	res_t   res;
	logic   res_valid_q;
	res_t   res_q;

	spq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (kind),
		.priority_req (priority_req),
		.payload_tag  (payload_tag),
		.busy         (busy),
		.ram_wr_en    (ram_wr_en),
		.ram_wr_addr  (ram_wr_addr),
		.ram_wr_data  (ram_wr_data),
		.ram_rd_en    (ram_rd_en),
		.ram_rd_addr  (ram_rd_addr),
		.ram_rd_data  (entry_t'(ram_rd_bits)),
		.res          (res)
	);

	spq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (EW'(ram_wr_data)),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_bits)
	);

	// Register the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res.valid;
		end
	end

	// Capture result fields when a request finishes
	always_ff @(posedge clk) begin
		if (res.valid) res_q <= res;
	end

	assign result_valid    = res_valid_q;
	assign pop_valid       = res_q.pop_valid;
	assign out_priority    = res_q.prio;
	assign out_payload_tag = res_q.tag;
	assign status          = res_q.status;
	assign occupancy       = res_q.occupancy;

endmodule

/* sv/spq_checker.sv */
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_unit_defines.svh.
`include "stable_priority_queue_unit_defines.svh"

module spq_checker
	import spq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 kind,
	input logic [PRIO_BITS-1:0] priority_req,
	input logic [TAG_BITS-1:0]  payload_tag,
	input logic                 result_valid,
	input logic                 pop_valid,
	input logic [PRIO_BITS-1:0] out_priority,
	input logic [TAG_BITS-1:0]  out_payload_tag,
	input logic [1:0]           status,
	input logic [CW-1:0]        occupancy
);

	// An accepted request either finishes next cycle or keeps the block busy
	`SPQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || result_valid)

	// A returned entry always comes with an ok status
	`SPQ_ASSERT_NOW(a_pop_ok, result_valid && pop_valid, status == ST_OK)

	// Results without an entry carry zero priority and tag
	`SPQ_ASSERT_NOW(a_no_entry_zero, result_valid && !pop_valid,
		out_priority == '0 && out_payload_tag == '0)

	// A dropped push only happens on a full queue
	`SPQ_ASSERT_NOW(a_full_occ, result_valid && status == ST_FULL,
		occupancy == CW'(DEPTH) && !pop_valid)

	// A pop on empty leaves the queue empty
	`SPQ_ASSERT_NOW(a_empty_occ, result_valid && status == ST_EMPTY,
		occupancy == '0 && !pop_valid)

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (.*);

/* tb/sv/spq_order_checker.sv */
`timescale 1ns / 100ps
// Watches the request and result channels of the stable priority queue, keeps its own
// sorted copy of the queue and checks every result. Depends on spq_pkg.
module spq_order_checker
	import spq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 kind,
	input  logic [PRIO_BITS-1:0] priority_req,
	input  logic [TAG_BITS-1:0]  payload_tag,
	input  logic                 result_valid,
	input  logic                 pop_valid,
	input  logic [PRIO_BITS-1:0] out_priority,
	input  logic [TAG_BITS-1:0]  out_payload_tag,
	input  logic [1:0]           status,
	input  logic [CW-1:0]        occupancy,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic    pop_valid;
		prio_t   prio;
		tag_t    tag;
		status_t status;
		cnt_t    occupancy;
	} outcome_t;

	// Queue contents in service order, front at index 0
	entry_t   held[DEPTH];
	int       held_count = 0;
	outcome_t awaited_outcomes[$];
	int       fails = 0;

	// Apply one request to the held entries and return the outcome it must produce
	function automatic outcome_t serve_request(logic req_kind, prio_t p, tag_t t);
		outcome_t o;
		int       pos;
		int       i;
		o = '0;
		o.status = ST_OK;
		if (req_kind == KIND_PUSH) begin
			if (held_count >= DEPTH) begin
				o.status = ST_FULL;
			end else begin
				// insert behind every entry of equal or higher priority
				pos = 0;
				while (pos < held_count && held[pos].prio >= p)
					pos++;
				for (i = held_count; i > pos; i--)
					held[i] = held[i-1];
				held[pos].prio = p;
				held[pos].tag  = t;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				o.status = ST_EMPTY;
			end else begin
				o.pop_valid = 1'b1;
				o.prio      = held[0].prio;
				o.tag       = held[0].tag;
				for (i = 1; i < held_count; i++)
					held[i-1] = held[i];
				held_count--;
			end
		end
		o.occupancy = cnt_t'(held_count);
		return o;
	endfunction

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fails++;
		end
	endtask

	// Check results against the oldest outstanding request, then log newly accepted ones
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			held_count = 0;
			awaited_outcomes.delete();
		end else begin
			if (result_valid === 1'b1) begin
				if (awaited_outcomes.size() == 0) begin
					$display("%0t: result with no request outstanding", $time);
					fails++;
				end else begin
					want = awaited_outcomes[0];
					awaited_outcomes.delete(0);
					compare_field("pop_valid", want.pop_valid, pop_valid);
					compare_field("out_priority", want.prio, out_priority);
					compare_field("out_payload_tag", want.tag, out_payload_tag);
					compare_field("status", want.status, status);
					compare_field("occupancy", want.occupancy, occupancy);
				end
			end
			if (start && !busy)
				awaited_outcomes.push_back(serve_request(kind, priority_req, payload_tag));
		end
		fail_count <= fails;
		pending    <= awaited_outcomes.size();
	end

endmodule

/* tb/sv/stable_priority_queue_unit_test.sv */
`timescale 1ns / 100ps
// Stimulus and verdict for the stable priority queue: directed pushes and pops, then
// random fill, drain and mixed phases. Depends on spq_pkg, spq_order_checker and the block.
module stable_priority_queue_unit_test;
	import spq_pkg::*;

	localparam int RANDOM_REQUESTS = 450;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 kind;
	logic [PRIO_BITS-1:0] priority_req;
	logic [TAG_BITS-1:0]  payload_tag;
	logic                 result_valid;
	logic                 pop_valid;
	logic [PRIO_BITS-1:0] out_priority;
	logic [TAG_BITS-1:0]  out_payload_tag;
	logic [1:0]           status;
	logic [CW-1:0]        occupancy;
	int                   fail_count;
	int                   pending;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stable_priority_queue_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.priority_req    (priority_req),
		.payload_tag     (payload_tag),
		.result_valid    (result_valid),
		.pop_valid       (pop_valid),
		.out_priority    (out_priority),
		.out_payload_tag (out_payload_tag),
		.status          (status),
		.occupancy       (occupancy)
	);

	spq_order_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.priority_req    (priority_req),
		.payload_tag     (payload_tag),
		.result_valid    (result_valid),
		.pop_valid       (pop_valid),
		.out_priority    (out_priority),
		.out_payload_tag (out_payload_tag),
		.status          (status),
		.occupancy       (occupancy),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	// Present one request from a rising edge, hold it until accepted, then idle if asked
	task automatic send_request(logic req_kind, prio_t p, tag_t t, int gap);
		kind         <= req_kind;
		priority_req <= p;
		payload_tag  <= t;
		start        <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly back to back or short pauses, now and then a long one
	function automatic int pick_gap(int mode);
		int r;
		if (mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Favor a few small values so equal priorities collide often
	function automatic prio_t pick_priority();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return prio_t'($urandom_range(0, 3));
		if (r == 4)
			return '0;
		if (r == 5)
			return '1;
		return prio_t'($urandom);
	endfunction

	// End the run if the block hangs
	initial begin
		#(2_000_000);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int sent;
		int phase_kind;
		int phase_len;
		int push_pct;
		int gap_mode;
		int guard;
		logic req_kind;

		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = KIND_PUSH;
		priority_req = '0;
		payload_tag  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty pop, extremes, ties at both ends, drain past empty
		send_request(KIND_POP,  8'h00, 16'h0000, 0);
		send_request(KIND_PUSH, 8'h80, 16'h0001, 0);
		send_request(KIND_PUSH, 8'hFF, 16'hFFFF, 1);
		send_request(KIND_PUSH, 8'h00, 16'h0000, 0);
		send_request(KIND_PUSH, 8'h80, 16'h0002, 0);
		send_request(KIND_PUSH, 8'h80, 16'h0003, 2);
		send_request(KIND_PUSH, 8'hFF, 16'h1234, 0);
		send_request(KIND_PUSH, 8'h7F, 16'hAAAA, 0);
		send_request(KIND_PUSH, 8'h81, 16'h5555, 0);
		send_request(KIND_PUSH, 8'h00, 16'hFFFE, 0);
		repeat (9) send_request(KIND_POP, 8'hFF, 16'hFFFF, 0);
		send_request(KIND_POP,  8'h55, 16'h5A5A, 3);

		// Random: overflow, fill, drain and mixed phases
		sent       = 0;
		phase_kind = 3;
		while (sent < RANDOM_REQUESTS) begin
			case (phase_kind)
				0: begin
					push_pct  = 80;
					phase_len = $urandom_range(10, 40);
				end
				1: begin
					push_pct  = 20;
					phase_len = $urandom_range(10, 40);
				end
				2: begin
					push_pct  = 50;
					phase_len = $urandom_range(10, 40);
				end
				default: begin
					push_pct  = 100;
					phase_len = $urandom_range(18, 22);
				end
			endcase
			gap_mode = $urandom_range(0, 2) == 0 ? 0 : 1;
			repeat (phase_len) begin
				req_kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
				send_request(req_kind, pick_priority(), tag_t'($urandom), pick_gap(gap_mode));
				sent++;
			end
			phase_kind = $urandom_range(0, 3);
		end
		start <= 1'b0;

		// Wait for outstanding results, then let the block settle
		for (guard = 0; guard < 5000 && pending != 0; guard++)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (pending != 0)
			$display("%0t: %0d requests never answered", $time, pending);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* stable_priority_queue_unit.f */
+incdir+sv
sv/spq_pkg.sv
sv/spq_ram.sv
sv/spq_ctrl.sv
sv/stable_priority_queue_unit.sv
sv/spq_checker.sv
tb/sv/spq_order_checker.sv
tb/sv/stable_priority_queue_unit_test.sv
